### rtl/ofp_pkg.sv
`timescale 1ns / 1ps

package ofp_pkg;

   // coordinate bits taken from each input field, sign-extended
   localparam int COORD_WIDTH = 32;

   // fixed field widths
   localparam int IN_W   = 32;
   localparam int NORM_W = 32;
   localparam int OFF_W  = 41;

   // edge vectors and cross product
   localparam int CW     = COORD_WIDTH;
   localparam int EW     = CW + 1;
   localparam int HALF_W = 16;
   localparam int HI_W   = EW - HALF_W;
   localparam int PP_W   = 2 * EW;

   // limb split of the normal magnitude for the wide squares
   localparam int LIMB_W  = 32;
   localparam int LIMBS   = 3;
   localparam int MAG_W   = LIMB_W * LIMBS;
   localparam int LPROD_W = 2 * LIMB_W;
   localparam int SQF_W   = 2 * MAG_W;
   localparam int SDF_W   = LIMB_W * (LIMBS + 1);

   // squares, sum of squares and side test
   localparam int SQ_W     = 4 * CW + 2;
   localparam int S_W      = SQ_W + 2;
   localparam int SIDE_T_W = 3 * CW + 2;
   localparam int SIDE_W   = SIDE_T_W + 2;

   // bit-serial quotient, one bit per stage
   localparam int FRAC_W = 30;
   localparam int Q_W    = FRAC_W + 1;
   localparam int P_W    = S_W + Q_W;
   localparam int RW     = S_W + 2 * Q_W;

   // offset dot product
   localparam int PROD_W = NORM_W + CW;
   localparam int SUM_W  = PROD_W + 2;

   localparam int FRONT_STAGES = 8;

   typedef logic signed [EW-1:0]       edge_type;
   typedef logic [PP_W-1:0]            pp_type;
   typedef logic [MAG_W-1:0]           mag_type;
   typedef logic [LIMB_W-1:0]          limb_type;
   typedef logic [SQF_W-1:0]           sqf_type;
   typedef logic [SDF_W-1:0]           sdf_type;
   typedef logic [S_W-1:0]             sumsq_type;
   typedef logic signed [SIDE_W-1:0]   side_type;
   typedef logic [RW-1:0]              rem_type;
   typedef logic [P_W-1:0]             prod_type;
   typedef logic [Q_W-1:0]             quo_type;
   typedef logic [NORM_W-1:0]          norm_type;
   typedef logic signed [SUM_W-1:0]    sum_type;
   typedef logic [OFF_W-1:0]           off_type;

   // per-face flags and first corner, carried alongside the quotient lanes
   typedef struct packed {
      logic              degenerate;
      logic              flipped;
      logic [2:0]        neg;
      logic [2:0][CW-1:0] a;
   } tag_type;

endpackage

### rtl/oriented_face_plane.sv
`timescale 1ns / 1ps

// Plane of a triangular face with its unit normal turned toward a reference point.
// Request channel (req_valid/req_ready) carries corners a, b, c and the reference
// point, all Q16.16. Response channel (rsp_valid/rsp_ready) returns the normal in
// Q2.30, the plane offset in Q25.16, the flipped flag and the degenerate flag.
// One face is accepted per cycle unless the receiver stalls; the pipeline holds up
// to 43 faces in flight. From request transfer to response valid, 8 stages form
// the cross product, squares and side test, 31 stages produce the quotient one
// bit each (three lanes in parallel), and 4 stages form the offset and the
// output register.
// A degenerate face (zero area) returns zero normal and offset with the
// degenerate flag set.
// Synchronous reset clears all valid bits; the response channel is empty after.
// When the receiver stalls, the whole pipeline holds and req_ready drops, so
// nothing is lost or repeated; a pending response stays on the ports unchanged.

module oriented_face_plane (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_a_x,
   input  logic signed [31:0] req_a_y,
   input  logic signed [31:0] req_a_z,
   input  logic signed [31:0] req_b_x,
   input  logic signed [31:0] req_b_y,
   input  logic signed [31:0] req_b_z,
   input  logic signed [31:0] req_c_x,
   input  logic signed [31:0] req_c_y,
   input  logic signed [31:0] req_c_z,
   input  logic signed [31:0] req_ref_x,
   input  logic signed [31:0] req_ref_y,
   input  logic signed [31:0] req_ref_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_normal_x,
   output logic signed [31:0] rsp_normal_y,
   output logic signed [31:0] rsp_normal_z,
   output logic signed [40:0] rsp_plane_offset,
   output logic               rsp_flipped,
   output logic               rsp_degenerate
);

   logic enable;
   logic front_valid;
   logic [2:0][ofp_pkg::SQ_W-1:0]   square;
   logic [ofp_pkg::S_W-1:0]         sumsq;
   ofp_pkg::tag_type                front_tag;
   logic [2:0][ofp_pkg::Q_W-1:0]    quotient;
   logic [2:0][ofp_pkg::NORM_W-1:0] normal;
   logic [ofp_pkg::OFF_W-1:0]       offset;
   logic                            flipped;
   logic                            degenerate;

   // tag and valid ride alongside the quotient lanes
   ofp_pkg::tag_type tag_ff   [ofp_pkg::Q_W];
   logic [ofp_pkg::Q_W-1:0] valid_ff;

   // whole pipeline advances unless a response is held
   assign enable    = ~rsp_valid | rsp_ready;
   assign req_ready = enable;

   ofp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (req_valid),
      .a         ({req_a_z, req_a_y, req_a_x}),
      .b         ({req_b_z, req_b_y, req_b_x}),
      .c         ({req_c_z, req_c_y, req_c_x}),
      .r         ({req_ref_z, req_ref_y, req_ref_x}),
      .out_valid (front_valid),
      .square    (square),
      .sumsq     (sumsq),
      .tag       (front_tag)
   );

   for (genvar k = 0; k < 3; k++) begin : g_lane
      ofp_root u_root (
         .clock    (clock),
         .enable   (enable),
         .sumsq    (sumsq),
         .square   (square[k]),
         .quotient (quotient[k])
      );
   end

   // delay line matching the quotient lanes
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[ofp_pkg::Q_W-2:0], front_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         tag_ff[0] <= front_tag;
         for (int s = 1; s < ofp_pkg::Q_W; s++) begin
            tag_ff[s] <= tag_ff[s-1];
         end
      end
   end

   ofp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .enable     (enable),
      .in_valid   (valid_ff[ofp_pkg::Q_W-1]),
      .quotient   (quotient),
      .tag        (tag_ff[ofp_pkg::Q_W-1]),
      .out_valid  (rsp_valid),
      .normal     (normal),
      .offset     (offset),
      .flipped    (flipped),
      .degenerate (degenerate)
   );

   assign rsp_normal_x     = normal[0];
   assign rsp_normal_y     = normal[1];
   assign rsp_normal_z     = normal[2];
   assign rsp_plane_offset = offset;
   assign rsp_flipped      = flipped;
   assign rsp_degenerate   = degenerate;

endmodule

### rtl/ofp_front.sv
`timescale 1ns / 1ps

module ofp_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               enable,
   input  logic                               in_valid,
   input  logic [2:0][ofp_pkg::IN_W-1:0]      a,
   input  logic [2:0][ofp_pkg::IN_W-1:0]      b,
   input  logic [2:0][ofp_pkg::IN_W-1:0]      c,
   input  logic [2:0][ofp_pkg::IN_W-1:0]      r,
   output logic                               out_valid,
   output logic [2:0][ofp_pkg::SQ_W-1:0]      square,
   output logic [ofp_pkg::S_W-1:0]            sumsq,
   output ofp_pkg::tag_type                   tag
);

   logic [ofp_pkg::FRONT_STAGES-1:0] valid_ff;
   logic [ofp_pkg::FRONT_STAGES-1:0] valid_in;
   logic [2:0][ofp_pkg::CW-1:0]      a_ff [ofp_pkg::FRONT_STAGES-1];

   // stage 1: edges and reference offset
   ofp_pkg::edge_type e1_in [3];
   ofp_pkg::edge_type e2_in [3];
   ofp_pkg::edge_type d_in  [3];
   ofp_pkg::edge_type e1_ff [3];
   ofp_pkg::edge_type e2_ff [3];
   ofp_pkg::edge_type d_ff  [3];

   // stage 2: partial products of the six cross terms
   logic signed [2*ofp_pkg::HI_W-1:0]               hh_in [6];
   logic signed [ofp_pkg::HI_W+ofp_pkg::HALF_W:0]   hl_in [6];
   logic signed [ofp_pkg::HI_W+ofp_pkg::HALF_W:0]   lh_in [6];
   logic [2*ofp_pkg::HALF_W-1:0]                    ll_in [6];
   logic signed [2*ofp_pkg::HI_W-1:0]               hh_ff [6];
   logic signed [ofp_pkg::HI_W+ofp_pkg::HALF_W:0]   hl_ff [6];
   logic signed [ofp_pkg::HI_W+ofp_pkg::HALF_W:0]   lh_ff [6];
   logic [2*ofp_pkg::HALF_W-1:0]                    ll_ff [6];
   ofp_pkg::edge_type d2_ff [3];

   // stage 3: full cross terms
   ofp_pkg::pp_type   prod_in [6];
   ofp_pkg::pp_type   prod_ff [6];
   ofp_pkg::edge_type d3_ff   [3];

   // stage 4: normal components
   ofp_pkg::pp_type   n_in  [3];
   ofp_pkg::pp_type   n_ff  [3];
   ofp_pkg::edge_type d4_ff [3];

   // stage 5: magnitudes and signs
   ofp_pkg::mag_type  mag_in  [3];
   ofp_pkg::limb_type dmag_in [3];
   logic [2:0]        neg_in;
   logic [2:0]        sgn_in;
   ofp_pkg::mag_type  mag_ff  [3];
   ofp_pkg::limb_type dmag_ff [3];
   logic [2:0]        neg5_ff;
   logic [2:0]        sgn5_ff;

   // stage 6: limb products
   logic [ofp_pkg::LPROD_W-1:0] sqp_in [3][6];
   logic [ofp_pkg::LPROD_W-1:0] sdp_in [3][3];
   logic [ofp_pkg::LPROD_W-1:0] sqp_ff [3][6];
   logic [ofp_pkg::LPROD_W-1:0] sdp_ff [3][3];
   logic [2:0]                  neg6_ff;
   logic [2:0]                  sgn6_ff;

   // stage 7: squares and signed side terms
   logic [ofp_pkg::SQ_W-1:0]            sq_in   [3];
   logic signed [ofp_pkg::SIDE_T_W-1:0] term_in [3];
   logic [ofp_pkg::SQ_W-1:0]            sq_ff   [3];
   logic signed [ofp_pkg::SIDE_T_W-1:0] term_ff [3];
   logic [2:0]                          neg7_ff;

   // stage 8: sum of squares and side sign
   ofp_pkg::sumsq_type sumsq_in;
   ofp_pkg::side_type  side_in;
   logic [ofp_pkg::SQ_W-1:0] square_ff [3];
   ofp_pkg::sumsq_type sumsq_ff;
   ofp_pkg::tag_type   tag_ff;

   assign valid_in = {valid_ff[ofp_pkg::FRONT_STAGES-2:0], in_valid};

   for (genvar k = 0; k < 3; k++) begin : g_axis
      localparam int K1 = (k + 1) % 3;
      localparam int K2 = (k + 2) % 3;
      ofp_pkg::edge_type pa, pb, pc, pr;
      logic              nneg, dneg;
      ofp_pkg::pp_type   nabs;
      ofp_pkg::edge_type dabs;
      ofp_pkg::limb_type l0, l1, l2;
      ofp_pkg::sqf_type  sqf;
      ofp_pkg::sdf_type  sdf;
      logic [ofp_pkg::SIDE_T_W-1:0] tmag;

      // edges, only the low coordinate bits count
      assign pa = ofp_pkg::edge_type'($signed(a[k][ofp_pkg::CW-1:0]));
      assign pb = ofp_pkg::edge_type'($signed(b[k][ofp_pkg::CW-1:0]));
      assign pc = ofp_pkg::edge_type'($signed(c[k][ofp_pkg::CW-1:0]));
      assign pr = ofp_pkg::edge_type'($signed(r[k][ofp_pkg::CW-1:0]));
      assign e1_in[k] = pa - pb;
      assign e2_in[k] = pa - pc;
      assign d_in[k]  = pr - pa;

      // cross product terms: e1[k1]*e2[k2] and e2[k1]*e1[k2]
      assign hh_in[k] = $signed(e1_ff[K1][ofp_pkg::EW-1:ofp_pkg::HALF_W])
                      * $signed(e2_ff[K2][ofp_pkg::EW-1:ofp_pkg::HALF_W]);
      assign hl_in[k] = $signed(e1_ff[K1][ofp_pkg::EW-1:ofp_pkg::HALF_W])
                      * $signed({1'b0, e2_ff[K2][ofp_pkg::HALF_W-1:0]});
      assign lh_in[k] = $signed({1'b0, e1_ff[K1][ofp_pkg::HALF_W-1:0]})
                      * $signed(e2_ff[K2][ofp_pkg::EW-1:ofp_pkg::HALF_W]);
      assign ll_in[k] = e1_ff[K1][ofp_pkg::HALF_W-1:0] * e2_ff[K2][ofp_pkg::HALF_W-1:0];

      assign hh_in[k+3] = $signed(e2_ff[K1][ofp_pkg::EW-1:ofp_pkg::HALF_W])
                        * $signed(e1_ff[K2][ofp_pkg::EW-1:ofp_pkg::HALF_W]);
      assign hl_in[k+3] = $signed(e2_ff[K1][ofp_pkg::EW-1:ofp_pkg::HALF_W])
                        * $signed({1'b0, e1_ff[K2][ofp_pkg::HALF_W-1:0]});
      assign lh_in[k+3] = $signed({1'b0, e2_ff[K1][ofp_pkg::HALF_W-1:0]})
                        * $signed(e1_ff[K2][ofp_pkg::EW-1:ofp_pkg::HALF_W]);
      assign ll_in[k+3] = e2_ff[K1][ofp_pkg::HALF_W-1:0] * e1_ff[K2][ofp_pkg::HALF_W-1:0];

      // normal component
      assign n_in[k] = prod_ff[k] - prod_ff[k+3];

      // magnitudes for the unsigned limb products
      assign nneg       = n_ff[k][ofp_pkg::PP_W-1];
      assign nabs       = nneg ? (ofp_pkg::pp_type'(0) - n_ff[k]) : n_ff[k];
      assign mag_in[k]  = ofp_pkg::mag_type'(nabs);
      assign dneg       = d4_ff[k][ofp_pkg::EW-1];
      assign dabs       = dneg ? (ofp_pkg::edge_type'(0) - d4_ff[k]) : d4_ff[k];
      assign dmag_in[k] = ofp_pkg::limb_type'(dabs);
      assign neg_in[k]  = nneg;
      assign sgn_in[k]  = nneg ^ dneg;

      // limb products
      assign l0 = mag_ff[k][0 +: ofp_pkg::LIMB_W];
      assign l1 = mag_ff[k][ofp_pkg::LIMB_W +: ofp_pkg::LIMB_W];
      assign l2 = mag_ff[k][2*ofp_pkg::LIMB_W +: ofp_pkg::LIMB_W];
      assign sqp_in[k][0] = l0 * l0;
      assign sqp_in[k][1] = l0 * l1;
      assign sqp_in[k][2] = l1 * l1;
      assign sqp_in[k][3] = l0 * l2;
      assign sqp_in[k][4] = l1 * l2;
      assign sqp_in[k][5] = l2 * l2;
      assign sdp_in[k][0] = l0 * dmag_ff[k];
      assign sdp_in[k][1] = l1 * dmag_ff[k];
      assign sdp_in[k][2] = l2 * dmag_ff[k];

      // recombine limbs
      assign sqf = ofp_pkg::sqf_type'(sqp_ff[k][0])
                 + (ofp_pkg::sqf_type'(sqp_ff[k][1]) << (ofp_pkg::LIMB_W + 1))
                 + ((ofp_pkg::sqf_type'(sqp_ff[k][2])
                    + (ofp_pkg::sqf_type'(sqp_ff[k][3]) << 1)) << (2 * ofp_pkg::LIMB_W))
                 + (ofp_pkg::sqf_type'(sqp_ff[k][4]) << (3 * ofp_pkg::LIMB_W + 1))
                 + (ofp_pkg::sqf_type'(sqp_ff[k][5]) << (4 * ofp_pkg::LIMB_W));
      assign sq_in[k] = sqf[ofp_pkg::SQ_W-1:0];
      assign sdf = ofp_pkg::sdf_type'(sdp_ff[k][0])
                 + (ofp_pkg::sdf_type'(sdp_ff[k][1]) << ofp_pkg::LIMB_W)
                 + (ofp_pkg::sdf_type'(sdp_ff[k][2]) << (2 * ofp_pkg::LIMB_W));
      assign tmag = sdf[ofp_pkg::SIDE_T_W-1:0];
      assign term_in[k] = sgn6_ff[k] ? -tmag : tmag;
   end

   // full cross terms from the partial products
   for (genvar j = 0; j < 6; j++) begin : g_term
      assign prod_in[j] = (ofp_pkg::pp_type'(hh_ff[j]) << (2 * ofp_pkg::HALF_W))
                        + ((ofp_pkg::pp_type'(hl_ff[j]) + ofp_pkg::pp_type'(lh_ff[j]))
                           << ofp_pkg::HALF_W)
                        + ofp_pkg::pp_type'(ll_ff[j]);
   end

   // sums over the three axes
   assign sumsq_in = ofp_pkg::sumsq_type'(sq_ff[0]) + ofp_pkg::sumsq_type'(sq_ff[1])
                   + ofp_pkg::sumsq_type'(sq_ff[2]);
   assign side_in  = ofp_pkg::side_type'(term_ff[0]) + ofp_pkg::side_type'(term_ff[1])
                   + ofp_pkg::side_type'(term_ff[2]);

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (enable) begin
         a_ff[0] <= {a[2][ofp_pkg::CW-1:0], a[1][ofp_pkg::CW-1:0], a[0][ofp_pkg::CW-1:0]};
         for (int s = 1; s < ofp_pkg::FRONT_STAGES - 1; s++) begin
            a_ff[s] <= a_ff[s-1];
         end
         for (int k = 0; k < 3; k++) begin
            e1_ff[k]     <= e1_in[k];
            e2_ff[k]     <= e2_in[k];
            d_ff[k]      <= d_in[k];
            d2_ff[k]     <= d_ff[k];
            d3_ff[k]     <= d2_ff[k];
            d4_ff[k]     <= d3_ff[k];
            n_ff[k]      <= n_in[k];
            mag_ff[k]    <= mag_in[k];
            dmag_ff[k]   <= dmag_in[k];
            sq_ff[k]     <= sq_in[k];
            term_ff[k]   <= term_in[k];
            square_ff[k] <= sq_ff[k];
            for (int j = 0; j < 6; j++) begin
               sqp_ff[k][j] <= sqp_in[k][j];
            end
            for (int j = 0; j < 3; j++) begin
               sdp_ff[k][j] <= sdp_in[k][j];
            end
         end
         for (int j = 0; j < 6; j++) begin
            hh_ff[j]   <= hh_in[j];
            hl_ff[j]   <= hl_in[j];
            lh_ff[j]   <= lh_in[j];
            ll_ff[j]   <= ll_in[j];
            prod_ff[j] <= prod_in[j];
         end
         neg5_ff           <= neg_in;
         sgn5_ff           <= sgn_in;
         neg6_ff           <= neg5_ff;
         sgn6_ff           <= sgn5_ff;
         neg7_ff           <= neg6_ff;
         sumsq_ff          <= sumsq_in;
         tag_ff.degenerate <= (sumsq_in == '0);
         tag_ff.flipped    <= side_in[ofp_pkg::SIDE_W-1] | (side_in == '0);
         tag_ff.neg        <= neg7_ff;
         tag_ff.a          <= a_ff[ofp_pkg::FRONT_STAGES-2];
      end
   end

   assign out_valid = valid_ff[ofp_pkg::FRONT_STAGES-1];
   assign square    = {square_ff[2], square_ff[1], square_ff[0]};
   assign sumsq     = sumsq_ff;
   assign tag       = tag_ff;

endmodule

### rtl/ofp_root.sv
`timescale 1ns / 1ps

module ofp_root (
   input  logic                      clock,
   input  logic                      enable,
   input  logic [ofp_pkg::S_W-1:0]   sumsq,
   input  logic [ofp_pkg::SQ_W-1:0]  square,
   output logic [ofp_pkg::Q_W-1:0]   quotient
);

   // remainder, running q*S, quotient and S per bit stage
   ofp_pkg::rem_type   rem_ff  [ofp_pkg::Q_W];
   ofp_pkg::prod_type  prod_ff [ofp_pkg::Q_W];
   ofp_pkg::quo_type   quo_ff  [ofp_pkg::Q_W];
   ofp_pkg::sumsq_type sum_ff  [ofp_pkg::Q_W];

   for (genvar i = 0; i < ofp_pkg::Q_W; i++) begin : g_bit
      localparam int B = ofp_pkg::Q_W - 1 - i;
      ofp_pkg::rem_type   rem_prev, trial, rem_in;
      logic [ofp_pkg::RW:0] diff;
      ofp_pkg::prod_type  prod_prev, prod_in;
      ofp_pkg::quo_type   quo_prev, quo_in;
      ofp_pkg::sumsq_type sum_prev;
      logic               take;

      if (i == 0) begin : g_head
         // remainder starts at component^2 * 2^60
         assign rem_prev  = ofp_pkg::rem_type'(square) << (2 * ofp_pkg::FRAC_W);
         assign prod_prev = '0;
         assign quo_prev  = '0;
         assign sum_prev  = sumsq;
      end else begin : g_tail
         assign rem_prev  = rem_ff[i-1];
         assign prod_prev = prod_ff[i-1];
         assign quo_prev  = quo_ff[i-1];
         assign sum_prev  = sum_ff[i-1];
      end

      // (q + 2^b)^2 S - q^2 S = 2^(b+1) qS + 2^(2b) S
      assign trial = (ofp_pkg::rem_type'(prod_prev) << (B + 1))
                   + (ofp_pkg::rem_type'(sum_prev) << (2 * B));
      assign diff  = {1'b0, rem_prev} - {1'b0, trial};
      assign take  = ~diff[ofp_pkg::RW];

      assign rem_in  = take ? diff[ofp_pkg::RW-1:0] : rem_prev;
      assign prod_in = take ? prod_prev + (ofp_pkg::prod_type'(sum_prev) << B) : prod_prev;
      assign quo_in  = take ? quo_prev | (ofp_pkg::quo_type'(1) << B) : quo_prev;

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[i]  <= rem_in;
            prod_ff[i] <= prod_in;
            quo_ff[i]  <= quo_in;
            sum_ff[i]  <= sum_prev;
         end
      end
   end

   assign quotient = quo_ff[ofp_pkg::Q_W-1];

endmodule

### rtl/ofp_back.sv
`timescale 1ns / 1ps

module ofp_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              enable,
   input  logic                              in_valid,
   input  logic [2:0][ofp_pkg::Q_W-1:0]      quotient,
   input  ofp_pkg::tag_type                  tag,
   output logic                              out_valid,
   output logic [2:0][ofp_pkg::NORM_W-1:0]   normal,
   output logic [ofp_pkg::OFF_W-1:0]         offset,
   output logic                              flipped,
   output logic                              degenerate
);

   logic [3:0] valid_ff;

   // stage 1: signed quantized normal
   ofp_pkg::norm_type nq_in  [3];
   ofp_pkg::norm_type nq1_ff [3];
   ofp_pkg::tag_type  tag1_ff;

   // stage 2: products with the first corner
   logic signed [ofp_pkg::PROD_W-1:0] prod_in [3];
   logic signed [ofp_pkg::PROD_W-1:0] prod_ff [3];
   ofp_pkg::norm_type nq2_ff [3];
   ofp_pkg::tag_type  tag2_ff;

   // stage 3: dot product
   ofp_pkg::sum_type  sum_in;
   ofp_pkg::sum_type  sum_ff;
   ofp_pkg::norm_type nq3_ff [3];
   ofp_pkg::tag_type  tag3_ff;

   // stage 4: offset, orientation and output register
   logic                     sneg;
   logic [ofp_pkg::SUM_W-1:0] sabs;
   logic [ofp_pkg::SUM_W-1:0] smag;
   ofp_pkg::off_type         offm;
   ofp_pkg::off_type         off_in;
   ofp_pkg::norm_type        normal_in [3];
   ofp_pkg::norm_type        normal_ff [3];
   ofp_pkg::off_type         offset_ff;
   logic                     flipped_ff;
   logic                     degenerate_ff;

   for (genvar k = 0; k < 3; k++) begin : g_axis
      assign nq_in[k] = tag.neg[k]
                      ? ofp_pkg::norm_type'(0) - ofp_pkg::norm_type'(quotient[k])
                      : ofp_pkg::norm_type'(quotient[k]);
      assign prod_in[k] = $signed(nq1_ff[k]) * $signed(tag1_ff.a[k]);
      assign normal_in[k] = tag3_ff.degenerate ? '0
                          : (tag3_ff.flipped ? -nq3_ff[k] : nq3_ff[k]);
   end

   assign sum_in = ofp_pkg::sum_type'(prod_ff[0]) + ofp_pkg::sum_type'(prod_ff[1])
                 + ofp_pkg::sum_type'(prod_ff[2]);

   // shift toward zero, then orient
   assign sneg   = sum_ff[ofp_pkg::SUM_W-1];
   assign sabs   = sneg ? -sum_ff : sum_ff;
   assign smag   = sabs >> ofp_pkg::FRAC_W;
   assign offm   = ofp_pkg::off_type'(smag);
   assign off_in = tag3_ff.degenerate ? '0 : ((sneg ^ tag3_ff.flipped) ? -offm : offm);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < 3; k++) begin
            nq1_ff[k]    <= nq_in[k];
            prod_ff[k]   <= prod_in[k];
            nq2_ff[k]    <= nq1_ff[k];
            nq3_ff[k]    <= nq2_ff[k];
            normal_ff[k] <= normal_in[k];
         end
         tag1_ff       <= tag;
         tag2_ff       <= tag1_ff;
         tag3_ff       <= tag2_ff;
         sum_ff        <= sum_in;
         offset_ff     <= off_in;
         flipped_ff    <= tag3_ff.flipped & ~tag3_ff.degenerate;
         degenerate_ff <= tag3_ff.degenerate;
      end
   end

   assign out_valid  = valid_ff[3];
   assign normal     = {normal_ff[2], normal_ff[1], normal_ff[0]};
   assign offset     = offset_ff;
   assign flipped    = flipped_ff;
   assign degenerate = degenerate_ff;

endmodule

### rtl/ofp_checker.sv
`timescale 1ns / 1ps

module ofp_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_normal_x,
   input logic signed [31:0] rsp_normal_y,
   input logic signed [31:0] rsp_normal_z,
   input logic signed [40:0] rsp_plane_offset,
   input logic               rsp_flipped,
   input logic               rsp_degenerate
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_normal_x)
         && $stable(rsp_normal_y) && $stable(rsp_normal_z)
         && $stable(rsp_plane_offset) && $stable(rsp_flipped) && $stable(rsp_degenerate))
      else $error("response changed while stalled");

   // input side stalls only behind a held response
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow response stall");

   // degenerate face carries zero payload
   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_normal_x == 0 && rsp_normal_y == 0
         && rsp_normal_z == 0 && rsp_plane_offset == 0 && !rsp_flipped)
      else $error("degenerate face with nonzero payload");

   // unit normal components stay within one
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate |->
         rsp_normal_x <= 32'sd1073741824 && rsp_normal_x >= -32'sd1073741824
         && rsp_normal_y <= 32'sd1073741824 && rsp_normal_y >= -32'sd1073741824
         && rsp_normal_z <= 32'sd1073741824 && rsp_normal_z >= -32'sd1073741824)
      else $error("normal component out of range");

   // reset empties the response channel
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind oriented_face_plane ofp_checker u_ofp_checker (.*);
